/* rtl/assert_macros.svh */
// assertion macros used by the route update rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define DVR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// expression must never be true outside reset
`define DVR_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");

`else

`define DVR_ASSERT(label, clk, rst, prop)
`define DVR_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

/* rtl/dvr_pkg.sv */
// types and constants of the distance vector route update block
package dvr_pkg;

   // fixed field widths of the ports
   localparam int NODE_W    = 4;
   localparam int COST_W    = 16;
   localparam int SELF_W    = 4;
   localparam int NUM_W     = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 5;

   typedef logic [NODE_W-1:0]    node_type;
   typedef logic [COST_W-1:0]    cost_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   typedef logic [CSR_DAT_W-1:0] csr_dat_type;

   // request kinds
   localparam logic REQ_LINK   = 1'b0;
   localparam logic REQ_VECTOR = 1'b1;

   // register indexes
   localparam csr_idx_type CSR_SELF_INDEX = 2'd0;
   localparam csr_idx_type CSR_NUM_NODES  = 2'd1;

   // sequencer states
   localparam int ST_W = 2;
   localparam logic [ST_W-1:0] ST_CLEAR = 2'd0;
   localparam logic [ST_W-1:0] ST_IDLE  = 2'd1;
   localparam logic [ST_W-1:0] ST_RUN   = 2'd2;

endpackage

/* rtl/distance_vector_route_update.sv */
// distance vector route update: cost matrix and link table in rams, one via per cycle
// A link word sets the link cost, direct and alive flags of one node; a vector word
// stores one advertised cost in the cost matrix when its node and destination lie
// inside the node count n. A vector word marked last starts a relaxation run over n
// if a destination is left: for every destination other than self the sequencer
// reads the destination's link entry, then one via node per cycle (link entry plus
// matrix entry); the single read port of the cost matrix ram sets that rate. Results
// leave through an output register; the walk only stalls when that register is full
// and not taken. No request is accepted during a run. After reset a clearing pass
// writes every matrix entry (and the link table alongside) to its reset value, one
// entry a cycle; the request channel is held off meanwhile, register writes are
// taken as ever.
`include "assert_macros.svh"

module distance_vector_route_update #(
   parameter int MAX_NODES = 16,
   parameter int COST_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // register write port
   input  logic                  csr_we,
   input  dvr_pkg::csr_idx_type  csr_index,
   input  dvr_pkg::csr_dat_type  csr_wdata,
   // request words
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  dvr_pkg::node_type     req_node,
   input  dvr_pkg::node_type     req_dest,
   input  dvr_pkg::cost_type     req_cost,
   input  logic                  req_direct,
   input  logic                  req_alive,
   input  logic                  req_last,
   // result words
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dvr_pkg::node_type     rsp_dest_out,
   output dvr_pkg::cost_type     rsp_best_cost,
   output dvr_pkg::node_type     rsp_hop_node,
   output logic                  rsp_reachable,
   output logic                  rsp_last_out
);

   import dvr_pkg::*;

   // index width of a node, counter width that also holds the node count
   localparam int IDX_W   = $clog2(MAX_NODES);
   localparam int CNT_W   = $clog2(MAX_NODES + 1);
   // compare width, big enough for d+2 and for the 5 bit register
   localparam int CMP_RAW = $clog2(MAX_NODES + 3);
   localparam int CMP_W   = (CMP_RAW > NUM_W) ? CMP_RAW : NUM_W;
   localparam int AW      = 2 * IDX_W;
   localparam int LK_W    = COST_BITS + 2;

   localparam logic [COST_BITS-1:0] INF_COST = {COST_BITS{1'b1}};
   localparam logic [CMP_W-1:0]     MAX_CMP  = CMP_W'(MAX_NODES);

   // ---------------------------------------------------------------- registers
   logic [SELF_W-1:0]   self_ff, self_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [ST_W-1:0]     state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;

   // issue side of the walk
   logic                iss_active_ff, iss_active_in;
   logic [IDX_W-1:0]    iss_d_ff, iss_d_in;
   logic [CNT_W-1:0]    iss_s_ff, iss_s_in;

   // stage that meets the ram read data
   logic                stg_valid_ff, stg_valid_in;
   logic [IDX_W-1:0]    stg_d_ff;
   logic [CNT_W-1:0]    stg_s_ff;

   // running minimum of the current destination
   logic [COST_BITS-1:0] best_ff, best_in;
   logic [IDX_W-1:0]     hop_ff, hop_in;
   logic                 hv_ff, hv_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   node_type            rsp_dest_ff;
   cost_type            rsp_cost_ff;
   node_type            rsp_hop_ff;
   logic                rsp_reach_ff;
   logic                rsp_last_ff;

   // ---------------------------------------------------------------- ram ports
   logic                cm_we, cm_re;
   logic [AW-1:0]       cm_waddr, cm_raddr;
   logic [COST_BITS-1:0] cm_wdata, cm_rdata;
   logic                lk_we, lk_re;
   logic [IDX_W-1:0]    lk_waddr, lk_raddr;
   logic [LK_W-1:0]     lk_wdata, lk_rdata;

   // ---------------------------------------------------------------- helpers
   logic [CMP_W-1:0]    self_cmp, n_cmp, node_cmp, dest_cmp, iss_nd, stg_nd;
   logic [CNT_W-1:0]    n_cnt;
   logic [COST_BITS-1:0] in_cost;
   logic                req_fire, advance, out_load, res_last, stg_first, stg_fin;
   logic [IDX_W-1:0]    stg_v;
   logic [COST_BITS-1:0] lk_cost;
   logic                lk_direct, lk_alive;
   logic [COST_BITS:0]  sum_wide;
   logic [COST_BITS-1:0] cand;
   logic                take_via;

   // next destination after d, stepping over self
   function automatic logic [CMP_W-1:0] next_dest(input logic [CMP_W-1:0] d,
                                                  input logic [CMP_W-1:0] s);
      logic [CMP_W-1:0] nd;
      nd = d + CMP_W'(1);
      if (nd == s) begin
         nd = d + CMP_W'(2);
      end
      return nd;
   endfunction

   assign self_cmp = CMP_W'(self_ff);
   // node count clamped to the table size
   assign n_cmp    = (CMP_W'(num_ff) > MAX_CMP) ? MAX_CMP : CMP_W'(num_ff);
   assign n_cnt    = CNT_W'(n_cmp);
   assign node_cmp = CMP_W'(req_node);
   assign dest_cmp = CMP_W'(req_dest);
   assign in_cost  = COST_BITS'(req_cost);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // stage bookkeeping: step 0 reads the destination's own link entry
   assign stg_first = (stg_s_ff == '0);
   assign stg_fin   = (stg_s_ff == n_cnt);
   assign stg_v     = IDX_W'(stg_s_ff - CNT_W'(1));
   assign stg_nd    = next_dest(CMP_W'(stg_d_ff), self_cmp);
   assign res_last  = (stg_nd >= n_cmp);
   assign iss_nd    = next_dest(CMP_W'(iss_d_ff), self_cmp);

   // the walk only stops when a finished result finds the output register busy
   assign advance  = !(stg_valid_ff && stg_fin && rsp_valid_ff && !rsp_ready);
   assign out_load = stg_valid_ff && stg_fin && advance;

   // ---------------------------------------------------------------- relaxation
   assign lk_cost   = lk_rdata[LK_W-1:2];
   assign lk_direct = lk_rdata[1];
   assign lk_alive  = lk_rdata[0];

   // saturating via cost
   assign sum_wide = {1'b0, lk_cost} + {1'b0, cm_rdata};
   assign cand     = (sum_wide >= {1'b0, INF_COST}) ? INF_COST : sum_wide[COST_BITS-1:0];
   assign take_via = lk_alive && (CMP_W'(stg_v) != self_cmp) && (cand < best_ff);

   always_comb begin
      best_in = best_ff;
      hop_in  = hop_ff;
      hv_in   = hv_ff;
      if (stg_valid_ff && advance) begin
         if (stg_first) begin
            // start from the direct link, if any
            best_in = lk_direct ? lk_cost : INF_COST;
            hop_in  = stg_d_ff;
            hv_in   = lk_direct;
         end else if (take_via) begin
            best_in = cand;
            hop_in  = stg_v;
            hv_in   = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- registers
   always_comb begin
      self_in = self_ff;
      num_in  = num_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SELF_INDEX: self_in = csr_wdata[SELF_W-1:0];
            CSR_NUM_NODES:  num_in  = csr_wdata[NUM_W-1:0];
            default: begin
               // no register here
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      iss_active_in = iss_active_ff;
      iss_d_in      = iss_d_ff;
      iss_s_in      = iss_s_ff;
      cm_we         = 1'b0;
      cm_waddr      = {IDX_W'(self_ff), stg_d_ff};
      cm_wdata      = best_in;
      lk_we         = 1'b0;
      lk_waddr      = IDX_W'(req_node);
      lk_wdata      = {in_cost, req_direct, req_alive};
      cm_re         = 1'b0;
      lk_re         = 1'b0;
      cm_raddr      = {stg_v, iss_d_ff};
      lk_raddr      = iss_d_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep every entry back to its reset value
            cm_we    = 1'b1;
            cm_waddr = clr_ff;
            cm_wdata = INF_COST;
            lk_we    = 1'b1;
            lk_waddr = clr_ff[IDX_W-1:0];
            lk_wdata = {INF_COST, 1'b0, 1'b1};
            clr_in   = clr_ff + AW'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_type == REQ_LINK) begin
                  lk_we = (node_cmp < MAX_CMP);
               end else begin
                  cm_we    = (node_cmp < n_cmp) && (dest_cmp < n_cmp);
                  cm_waddr = {IDX_W'(req_node), IDX_W'(req_dest)};
                  cm_wdata = in_cost;
                  // a last word opens a run if any destination is left
                  if (req_last) begin
                     priority if (self_cmp == '0) begin
                        iss_d_in = IDX_W'(1);
                        if (n_cmp > CMP_W'(1)) begin
                           state_in      = ST_RUN;
                           iss_active_in = 1'b1;
                        end
                     end else begin
                        iss_d_in = '0;
                        if (n_cmp != '0) begin
                           state_in      = ST_RUN;
                           iss_active_in = 1'b1;
                        end
                     end
                     iss_s_in = '0;
                  end
               end
            end
         end
         ST_RUN: begin
            // issue one read pair per cycle while the walk is not stalled
            if (iss_active_ff && advance) begin
               cm_re    = 1'b1;
               lk_re    = 1'b1;
               cm_raddr = {IDX_W'(iss_s_ff - CNT_W'(1)), iss_d_ff};
               lk_raddr = (iss_s_ff == '0) ? iss_d_ff : IDX_W'(iss_s_ff - CNT_W'(1));
               if (iss_s_ff == n_cnt) begin
                  iss_s_in = '0;
                  if (iss_nd >= n_cmp) begin
                     iss_active_in = 1'b0;
                  end else begin
                     iss_d_in = IDX_W'(iss_nd);
                  end
               end else begin
                  iss_s_in = iss_s_ff + CNT_W'(1);
               end
            end
            // own row takes the new cost, only when self lies in the table
            if (out_load) begin
               cm_we = (self_cmp < MAX_CMP);
               if (res_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign stg_valid_in = advance ? (iss_active_ff && (state_ff == ST_RUN)) : stg_valid_ff;
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         self_ff       <= '0;
         num_ff        <= NUM_W'(16);
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         iss_active_ff <= 1'b0;
         stg_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         self_ff       <= self_in;
         num_ff        <= num_in;
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         iss_active_ff <= iss_active_in;
         stg_valid_ff  <= stg_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload and walk position, no reset needed
   always_ff @(posedge clock) begin
      iss_d_ff <= iss_d_in;
      iss_s_ff <= iss_s_in;
      best_ff  <= best_in;
      hop_ff   <= hop_in;
      hv_ff    <= hv_in;
      if (advance) begin
         stg_d_ff <= iss_d_ff;
         stg_s_ff <= iss_s_ff;
      end
      if (out_load) begin
         rsp_dest_ff  <= NODE_W'(stg_d_ff);
         rsp_cost_ff  <= COST_W'(best_in);
         rsp_hop_ff   <= hv_in ? NODE_W'(hop_in) : '0;
         rsp_reach_ff <= hv_in;
         rsp_last_ff  <= res_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_dest_out  = rsp_dest_ff;
   assign rsp_best_cost = rsp_cost_ff;
   assign rsp_hop_node  = rsp_hop_ff;
   assign rsp_reachable = rsp_reach_ff;
   assign rsp_last_out  = rsp_last_ff;

   // ---------------------------------------------------------------- memories
   // cost matrix, row = advertising node, column = destination
   dvr_ram #(
      .DATA_W (COST_BITS),
      .ADDR_W (AW)
   ) u_cost_ram (
      .clock (clock),
      .we    (cm_we),
      .waddr (cm_waddr),
      .wdata (cm_wdata),
      .re    (cm_re),
      .raddr (cm_raddr),
      .rdata (cm_rdata)
   );

   // link table: cost, direct flag, alive flag
   dvr_ram #(
      .DATA_W (LK_W),
      .ADDR_W (IDX_W)
   ) u_link_ram (
      .clock (clock),
      .we    (lk_we),
      .waddr (lk_waddr),
      .wdata (lk_wdata),
      .re    (lk_re),
      .raddr (lk_raddr),
      .rdata (lk_rdata)
   );

   // ---------------------------------------------------------------- checks
   `DVR_ASSERT_NEVER(a_clear_quiet, clock, reset, (state_ff == ST_CLEAR) && (rsp_valid_ff || stg_valid_ff))
   `DVR_ASSERT(a_stage_in_run, clock, reset, stg_valid_ff |-> (state_ff == ST_RUN))
   `DVR_ASSERT(a_final_drained, clock, reset, (out_load && res_last) |-> !iss_active_ff)
   `DVR_ASSERT(a_stall_holds, clock, reset, (stg_valid_ff && !advance) |=> (stg_valid_ff && $stable(stg_s_ff) && $stable(stg_d_ff)))

endmodule

/* rtl/dvr_ram.sv */
// simple dual port synchronous ram, one write and one registered read port
module dvr_ram #(
   parameter int DATA_W = 16,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read data holds while re is low
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* bench/distance_vector_route_update_test.sv */
// self-checking bench for distance_vector_route_update: directed table, then random phases
module distance_vector_route_update_test;
   import dvr_pkg::*;

   localparam int       NODES         = 16;
   localparam cost_type COST_INF      = '1;
   // settle time after each drain, meant to cover a full relaxation run with no output
   localparam int       SETTLE_CYCLES = 300;
   localparam int       HOLD_CYCLES   = 600;
   localparam int       STALL_LIMIT   = 5000;
   localparam int       PHASE_WORDS   = 36;

   // one request word as it sits on the req_ ports
   typedef struct packed {
      logic     kind;
      node_type node;
      node_type dest;
      cost_type cost;
      logic     direct;
      logic     alive;
      logic     last;
   } req_word_type;

   // one route word as it leaves on the rsp_ ports
   typedef struct packed {
      node_type dest;
      cost_type cost;
      node_type hop;
      logic     reach;
      logic     last;
   } route_type;

   // one line of the directed table: a register write or a request word, with an
   // optional typed-in cost, hop and reach that every route of the run must show
   typedef struct packed {
      logic         is_csr;
      csr_idx_type  csr_idx;
      csr_dat_type  csr_val;
      req_word_type word;
      logic         typed;
      cost_type     t_cost;
      node_type     t_hop;
      logic         t_reach;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   csr_idx_type csr_index;
   csr_dat_type csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic        req_type;
   node_type    req_node;
   node_type    req_dest;
   cost_type    req_cost;
   logic        req_direct;
   logic        req_alive;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_ready;
   node_type    rsp_dest_out;
   cost_type    rsp_best_cost;
   node_type    rsp_hop_node;
   logic        rsp_reachable;
   logic        rsp_last_out;

   distance_vector_route_update u_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_node      (req_node),
      .req_dest      (req_dest),
      .req_cost      (req_cost),
      .req_direct    (req_direct),
      .req_alive     (req_alive),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_dest_out  (rsp_dest_out),
      .rsp_best_cost (rsp_best_cost),
      .rsp_hop_node  (rsp_hop_node),
      .rsp_reachable (rsp_reachable),
      .rsp_last_out  (rsp_last_out)
   );

   always #2 clock = ~clock;

   // bench copy of the tables: route_cost[via][dest] is what via advertises
   cost_type          route_cost [NODES][NODES];
   cost_type          link_cost_tbl [NODES];
   logic              direct_tbl [NODES];
   logic              alive_tbl [NODES];
   logic [SELF_W-1:0] self_reg;
   logic [NUM_W-1:0]  nodes_reg;

   route_type    fresh_routes[$];    // routes caused by the word just taken
   route_type    pending_routes[$];  // routes still to come out, oldest first
   plan_row_type plan[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_request   = 1'b0;
   int mismatches     = 0;
   int stall_cycles   = 0;

   // node count in use, clamped to the table size
   function automatic int active_nodes();
      return (nodes_reg > NODES) ? NODES : int'(nodes_reg);
   endfunction

   // apply one taken word to the bench tables and work out the routes it causes
   function automatic void update_routes(input req_word_type w);
      int        n;
      int        d;
      int        v;
      cost_type  best;
      cost_type  cand;
      node_type  hop;
      logic      reach;
      logic [COST_W:0] sum;
      route_type r;
      fresh_routes.delete();
      n = active_nodes();
      if (w.kind == REQ_LINK) begin
         // every 4-bit node is inside the table, and a link word never starts a run
         link_cost_tbl[w.node] = w.cost;
         direct_tbl[w.node]    = w.direct;
         alive_tbl[w.node]     = w.alive;
         return;
      end
      // out-of-range entries are dropped, but their last mark still counts
      if (w.node < n && w.dest < n)
         route_cost[w.node][w.dest] = w.cost;
      if (!w.last)
         return;
      for (d = 0; d < n; d++) begin
         if (d == self_reg)
            continue;
         // a direct link is the starting point, even at infinite cost
         if (direct_tbl[d]) begin
            best  = link_cost_tbl[d];
            hop   = node_type'(d);
            reach = 1'b1;
         end else begin
            best  = COST_INF;
            hop   = '0;
            reach = 1'b0;
         end
         for (v = 0; v < n; v++) begin
            if (v == self_reg || !alive_tbl[v])
               continue;
            sum  = {1'b0, link_cost_tbl[v]} + {1'b0, route_cost[v][d]};
            cand = (sum >= COST_INF) ? COST_INF : sum[COST_W-1:0];
            // only a strictly better sum moves the hop
            if (cand < best) begin
               best  = cand;
               hop   = node_type'(v);
               reach = 1'b1;
            end
         end
         // self is 4 bits wide, so the own row always lies inside the table
         route_cost[self_reg][d] = best;
         r.dest  = node_type'(d);
         r.cost  = best;
         r.hop   = reach ? hop : '0;
         r.reach = reach;
         r.last  = 1'b0;
         fresh_routes.push_back(r);
      end
      if (fresh_routes.size() > 0)
         fresh_routes[fresh_routes.size()-1].last = 1'b1;
   endfunction

   function automatic cost_type pick_cost();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return COST_INF;
         2, 3:    return cost_type'($urandom_range(0, 16'hFFFF));
         default: return cost_type'($urandom_range(1, 40));
      endcase
   endfunction

   function automatic plan_row_type csr_row(input csr_idx_type idx, input csr_dat_type val);
      plan_row_type r;
      r         = '0;
      r.is_csr  = 1'b1;
      r.csr_idx = idx;
      r.csr_val = val;
      return r;
   endfunction

   function automatic plan_row_type link_row(input node_type nd, input cost_type c,
                                             input logic dir, input logic alv, input logic lst);
      plan_row_type r;
      r             = '0;
      r.word.kind   = REQ_LINK;
      r.word.node   = nd;
      r.word.cost   = c;
      r.word.direct = dir;
      r.word.alive  = alv;
      r.word.last   = lst;
      return r;
   endfunction

   function automatic plan_row_type vec_row(input node_type nd, input node_type ds,
                                            input cost_type c, input logic lst);
      plan_row_type r;
      r           = '0;
      r.word.kind = REQ_VECTOR;
      r.word.node = nd;
      r.word.dest = ds;
      r.word.cost = c;
      r.word.last = lst;
      return r;
   endfunction

   function automatic plan_row_type with_route(input plan_row_type r, input cost_type c,
                                               input node_type h, input logic rch);
      plan_row_type t;
      t         = r;
      t.typed   = 1'b1;
      t.t_cost  = c;
      t.t_hop   = h;
      t.t_reach = rch;
      return t;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   // offer one request word, after a random gap, and hold it until it is taken
   task automatic send_word(input plan_row_type row);
      route_type r;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_type   <= row.word.kind;
      req_node   <= row.word.node;
      req_dest   <= row.word.dest;
      req_cost   <= row.word.cost;
      req_direct <= row.word.direct;
      req_alive  <= row.word.alive;
      req_last   <= row.word.last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      // taken at this edge: queue up whatever routes it causes
      update_routes(row.word);
      foreach (fresh_routes[k]) begin
         r = fresh_routes[k];
         if (row.typed) begin
            r.cost  = row.t_cost;
            r.hop   = row.t_hop;
            r.reach = row.t_reach;
         end
         pending_routes.push_back(r);
      end
   endtask

   // stop offering, wait for every pending route, then let the block go quiet
   task automatic drain(input int extra);
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_routes.size() != 0);
      repeat (extra)
         @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input csr_dat_type val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_SELF_INDEX)
         self_reg = val[SELF_W-1:0];
      else if (idx == CSR_NUM_NODES)
         nodes_reg = val[NUM_W-1:0];
   endtask

   // mostly whole vectors with random costs, some cut short, plus link words and noise
   task automatic random_phase(input int words, input bit pause_mid);
      int           sent;
      int           n;
      int           len;
      int           k;
      int           pick;
      bit           paused;
      node_type     nb;
      plan_row_type row;
      sent   = 0;
      paused = 1'b0;
      n      = active_nodes();
      while (sent < words) begin
         if (pause_mid && !paused && sent >= words / 2) begin
            // sender sits idle until every route has come back
            drain(0);
            paused = 1'b1;
         end
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            send_word(link_row(node_type'($urandom_range(0, NODES-1)), pick_cost(),
                               1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0,
                               1'($urandom_range(0, 1))));
            sent++;
         end else if (pick < 8 && n > 0) begin
            nb  = node_type'($urandom_range(0, n-1));
            len = ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, n)) : n;
            for (k = 0; k < len; k++) begin
               row             = vec_row(nb, node_type'(k), pick_cost(), k == len - 1);
               row.word.direct = 1'($urandom_range(0, 1));
               row.word.alive  = 1'($urandom_range(0, 1));
               send_word(row);
               sent++;
            end
         end else begin
            row             = '0;
            row.word.kind   = 1'($urandom_range(0, 1));
            row.word.node   = node_type'($urandom_range(0, 15));
            row.word.dest   = node_type'($urandom_range(0, 15));
            row.word.cost   = cost_type'($urandom_range(0, 16'hFFFF));
            row.word.direct = 1'($urandom_range(0, 1));
            row.word.alive  = 1'($urandom_range(0, 1));
            row.word.last   = 1'($urandom_range(0, 1));
            send_word(row);
            sent++;
         end
      end
   endtask

   // compare every route word taken against the oldest one pending
   always @(posedge clock) begin : route_check
      route_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_routes.size() == 0) begin
            mismatches++;
            $display("%0t: route word with none expected, expected nothing, got %0h %0h %0h",
                     $time, rsp_dest_out, rsp_best_cost, rsp_hop_node);
         end else begin
            want = pending_routes.pop_front();
            check_field("dest_out", want.dest, rsp_dest_out);
            check_field("best_cost", want.cost, rsp_best_cost);
            check_field("hop_node", want.hop, rsp_hop_node);
            check_field("reachable", want.reach, rsp_reachable);
            check_field("last_out", want.last, rsp_last_out);
         end
      end
   end

   // result side: random stalls, and on request one long hold-off counted here
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            repeat (HOLD_CYCLES) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // watchdog: too many cycles in a row with no word taken on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int ph;
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      req_valid  <= 1'b0;
      req_type   <= 1'b0;
      req_node   <= '0;
      req_dest   <= '0;
      req_cost   <= '0;
      req_direct <= 1'b0;
      req_alive  <= 1'b0;
      req_last   <= 1'b0;

      // bench tables at their reset values
      for (int v = 0; v < NODES; v++) begin
         for (int d = 0; d < NODES; d++)
            route_cost[v][d] = COST_INF;
         link_cost_tbl[v] = COST_INF;
         direct_tbl[v]    = 1'b0;
         alive_tbl[v]     = 1'b1;
      end
      self_reg  = '0;
      nodes_reg = 5'd16;

      // directed table, starting from the reset settings (self 0, sixteen nodes)
      plan.push_back(vec_row(4'd1, 4'd2, 16'h1234, 1'b0));
      // fresh tables: nothing reachable anywhere
      plan.push_back(with_route(vec_row(4'd3, 4'd3, '0, 1'b1), COST_INF, '0, 1'b0));
      // two nodes, so each run gives a single route, to node 1
      plan.push_back(csr_row(CSR_NUM_NODES, 5'd2));
      plan.push_back(link_row(4'd1, '0, 1'b1, 1'b1, 1'b0));
      plan.push_back(with_route(vec_row(4'd0, 4'd0, '0, 1'b1), '0, 4'd1, 1'b1));
      // direct link at infinite cost still counts as a hop
      plan.push_back(link_row(4'd1, COST_INF, 1'b1, 1'b1, 1'b0));
      plan.push_back(with_route(vec_row(4'd1, 4'd1, '0, 1'b1), COST_INF, 4'd1, 1'b1));
      // relaxation through node 1, then sums at and around saturation
      plan.push_back(link_row(4'd1, 16'd5, 1'b0, 1'b1, 1'b0));
      plan.push_back(with_route(vec_row(4'd1, 4'd1, 16'd7, 1'b1), 16'd12, 4'd1, 1'b1));
      plan.push_back(with_route(vec_row(4'd1, 4'd1, 16'hFFFE, 1'b1), COST_INF, '0, 1'b0));
      plan.push_back(with_route(vec_row(4'd1, 4'd1, 16'hFFFA, 1'b1), COST_INF, '0, 1'b0));
      plan.push_back(with_route(vec_row(4'd1, 4'd1, 16'hFFF9, 1'b1), 16'hFFFE, 4'd1, 1'b1));
      // dead neighbour, set by a link word that also carries last (no run)
      plan.push_back(link_row(4'd1, 16'd5, 1'b0, 1'b0, 1'b1));
      plan.push_back(with_route(vec_row(4'd1, 4'd1, '0, 1'b1), COST_INF, '0, 1'b0));
      // entry outside the node count is dropped, its last mark still runs
      plan.push_back(with_route(vec_row(4'd2, 4'd0, '0, 1'b1), COST_INF, '0, 1'b0));
      plan.push_back(link_row(4'd15, '0, 1'b1, 1'b1, 1'b1));
      // self outside the node count: both destinations come out
      plan.push_back(csr_row(CSR_SELF_INDEX, 5'd15));
      plan.push_back(vec_row(4'd1, 4'd0, 16'd3, 1'b1));
      // no nodes at all: the last mark starts no run and gives no routes
      plan.push_back(csr_row(CSR_NUM_NODES, 5'd0));
      plan.push_back(vec_row(4'd0, 4'd0, '0, 1'b1));
      // oversized node count clamps to the table size
      plan.push_back(csr_row(CSR_NUM_NODES, 5'd31));
      plan.push_back(csr_row(CSR_SELF_INDEX, 5'd5));
      plan.push_back(link_row(4'd0, 16'd1, 1'b1, 1'b1, 1'b0));
      plan.push_back(vec_row(4'd15, 4'd15, COST_INF, 1'b1));
      plan.push_back(link_row(4'd7, COST_INF, 1'b1, 1'b0, 1'b0));
      plan.push_back(vec_row(4'd7, 4'd4, 16'd2, 1'b1));

      repeat (6)
         @(posedge clock);
      reset <= 1'b0;

      // registers only change once the block has gone quiet
      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            drain(SETTLE_CYCLES);
            write_reg(plan[i].csr_idx, plan[i].csr_val);
         end else begin
            send_word(plan[i]);
         end
      end

      for (ph = 0; ph < 8; ph++) begin
         drain(SETTLE_CYCLES);
         case (ph)
            0: begin
               write_reg(CSR_SELF_INDEX, 5'd0);
               write_reg(CSR_NUM_NODES, 5'd16);
            end
            1: begin
               write_reg(CSR_SELF_INDEX, 5'd15);
               write_reg(CSR_NUM_NODES, 5'd16);
            end
            2: begin
               write_reg(CSR_SELF_INDEX, csr_dat_type'($urandom_range(0, 15)));
               write_reg(CSR_NUM_NODES, csr_dat_type'($urandom_range(2, 8)));
            end
            3: begin
               write_reg(CSR_SELF_INDEX, csr_dat_type'($urandom_range(0, 15)));
               write_reg(CSR_NUM_NODES, 5'd31);
            end
            4: begin
               write_reg(CSR_SELF_INDEX, csr_dat_type'($urandom_range(0, 3)));
               write_reg(CSR_NUM_NODES, 5'd4);
            end
            5: begin
               // one node and self elsewhere: a single route per run
               write_reg(CSR_SELF_INDEX, csr_dat_type'($urandom_range(1, 15)));
               write_reg(CSR_NUM_NODES, 5'd1);
            end
            6: begin
               write_reg(CSR_SELF_INDEX, csr_dat_type'($urandom_range(0, 15)));
               write_reg(CSR_NUM_NODES, csr_dat_type'($urandom_range(0, 31)));
            end
            default: begin
               write_reg(CSR_SELF_INDEX, csr_dat_type'($urandom_range(0, 15)));
               write_reg(CSR_NUM_NODES, 5'd16);
            end
         endcase
         case (ph % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 63;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 63;
            end
            default: begin
               send_idle_pct  = 20;
               recv_stall_pct = 20;
            end
         endcase
         // last phase: result side holds off while words keep coming, so the block backs up
         if (ph == 7)
            hold_request = 1'b1;
         random_phase(PHASE_WORDS, ph == 4);
      end

      drain(SETTLE_CYCLES);
      if (mismatches == 0 && pending_routes.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
